FILE: design/gac_pkg.sv
// shared types, codes and constants of the gamepad axis conditioner
package gac_pkg;

  // serial divider geometry
  localparam int DivWidth = 17;
  localparam int DvdWidth = 2 * DivWidth;
  localparam int CntWidth = $clog2(DivWidth + 1);

  typedef logic [2:0]         axis_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         target_t;
  typedef logic [2:0]         cfg_idx_t;
  typedef logic signed [15:0] level_t;
  typedef logic signed [16:0] delta_t;
  typedef logic signed [1:0]  hat_t;

  // axis numbers
  localparam axis_t AX_LX   = 3'd0;
  localparam axis_t AX_LY   = 3'd1;
  localparam axis_t AX_RX   = 3'd2;
  localparam axis_t AX_RY   = 3'd3;
  localparam axis_t AX_LT   = 3'd4;
  localparam axis_t AX_RT   = 3'd5;
  localparam axis_t AX_HATX = 3'd6;
  localparam axis_t AX_HATY = 3'd7;

  // result kinds
  localparam kind_t KIND_STICK = 2'd0;
  localparam kind_t KIND_TRIG  = 2'd1;
  localparam kind_t KIND_KEY   = 2'd2;

  // targets
  localparam target_t TGT_LEFT  = 2'd0;
  localparam target_t TGT_RIGHT = 2'd1;
  localparam target_t KEY_N     = 2'd0;
  localparam target_t KEY_S     = 2'd1;
  localparam target_t KEY_W     = 2'd2;
  localparam target_t KEY_E     = 2'd3;

  // register indexes
  localparam cfg_idx_t REG_LEFT_DZ  = 3'd0;
  localparam cfg_idx_t REG_RIGHT_DZ = 3'd1;
  localparam cfg_idx_t REG_STK_MIN  = 3'd2;
  localparam cfg_idx_t REG_STK_MAX  = 3'd3;
  localparam cfg_idx_t REG_TRG_MIN  = 3'd4;
  localparam cfg_idx_t REG_TRG_MAX  = 3'd5;

  // register reset values
  localparam logic [15:0] DzReset     = 16'd5243;
  localparam level_t      StkMinReset = -16'sd32768;
  localparam level_t      StkMaxReset = 16'sd32767;
  localparam level_t      TrgMinReset = 16'sd0;
  localparam level_t      TrgMaxReset = 16'sd255;

  // arithmetic constants
  localparam logic [15:0]         DzCap    = 16'd62259;
  localparam logic [DivWidth-1:0] OneQ15   = 17'd32768;
  localparam logic [DivWidth-1:0] FullQ16  = 17'd65536;
  localparam level_t              LevelMax = 16'sd32767;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MID,
    ST_APPLY,
    ST_HAT,
    ST_PRESS
  } gac_state_t;

  // request to the serial divider
  typedef struct packed {
    logic                start;
    logic [DvdWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/gac_ifs.sv
// valid/ready channel interfaces for axis events and conditioned results
interface gac_in_if import gac_pkg::*; ();
  logic   valid;
  logic   ready;
  axis_t  axis;
  level_t raw_value;

  modport source (output valid, output axis, output raw_value, input ready);
  modport sink (input valid, input axis, input raw_value, output ready);
endinterface

interface gac_out_if import gac_pkg::*; ();
  logic    valid;
  logic    ready;
  kind_t   kind;
  target_t target;
  level_t  level_a;
  level_t  level_b;
  delta_t  delta_a;
  delta_t  delta_b;
  logic    pressed;
  logic    last;

  modport source (output valid, output kind, output target, output level_a,
                  output level_b, output delta_a, output delta_b, output pressed,
                  output last, input ready);
  modport sink (input valid, input kind, input target, input level_a,
                input level_b, input delta_a, input delta_b, input pressed,
                input last, output ready);
endinterface

FILE: design/gac_div.sv
// restoring divider, one quotient bit per cycle
module gac_div import gac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  div_req_t            req,
  output logic [DivWidth-1:0] quotient,
  output logic                done
);

  logic [DivWidth-1:0] rem_r;
  logic [DivWidth-1:0] quo_r;
  logic [DivWidth-1:0] dvs_r;
  logic [CntWidth-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DivWidth:0]   shifted;
  logic [DivWidth+1:0] diff;
  logic                fits;

  // remainder shifted by one dividend bit, then trial subtract
  assign shifted = {rem_r, quo_r[DivWidth-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[DivWidth+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntWidth'(DivWidth);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntWidth'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[DvdWidth-1:DivWidth];
      quo_r <= req.dividend[DivWidth-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DivWidth-1:0] : shifted[DivWidth-1:0];
      quo_r <= {quo_r[DivWidth-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: design/gamepad_axis_conditioner_top.sv
// gamepad axis conditioner: stick, trigger and hat event processing
//
//  channel   direction  handshake        word
//  in_chan   in         valid / ready    axis, raw_value
//  out_chan  out        valid / ready    kind, target, level_a/b, delta_a/b, pressed, last
//  cfg_*     in         write enable     cfg_index, cfg_wdata (no read-back)
//
// each event is taken only in idle; a stick makes two divider passes, or at most one
//   when clamped or inside the deadzone; a trigger makes one, or none when zero or
//   full; a hat makes none; the divider yields one quotient bit per clock
// reset: synchronous, active low; all stored axis values and hats go to zero
// stalls: one output register; a finished word waits there while the next event
//   is accepted, and a hat with two words holds until the first one has left
module gamepad_axis_conditioner_top import gac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  gac_in_if.sink           in_chan,
  gac_out_if.source        out_chan,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [15:0]      cfg_wdata
);

  // configuration registers
  logic [15:0] ldz_r, rdz_r;
  level_t      smin_r, smax_r, tmin_r, tmax_r;

  // stored axis state
  level_t lsx_r, lsy_r, rsx_r, rsy_r, ltl_r, rtl_r;
  hat_t   hatx_r, haty_r;

  // sequencer
  gac_state_t state_r, state_nxt;
  axis_t      axis_r;
  level_t     raw_r;
  logic       neg_r, sat_r, zero_r, phase2_r;

  // divider
  div_req_t            div_req;
  logic [DivWidth-1:0] quo;
  logic                div_done;

  // output register
  logic    out_valid_r;
  kind_t   kind_r, kind_nxt;
  target_t target_r, target_nxt;
  level_t  level_a_r, level_a_nxt, level_b_r, level_b_nxt;
  delta_t  delta_a_r, delta_a_nxt, delta_b_r, delta_b_nxt;
  logic    pressed_r, pressed_nxt, last_r, last_nxt;
  logic    load_out, out_free;
  logic    apply_go, hat_go;

  // axis decode
  logic is_stick, is_trig, is_right, is_y, is_haty;
  assign is_stick = axis_r <= AX_RY;
  assign is_trig  = (axis_r == AX_LT) || (axis_r == AX_RT);
  assign is_right = (axis_r == AX_RX) || (axis_r == AX_RY) || (axis_r == AX_RT);
  assign is_y     = (axis_r == AX_LY) || (axis_r == AX_RY);
  assign is_haty  = axis_r == AX_HATY;

  // stick prep: centre on the range and set up |num|*32768/den
  logic signed [18:0]  s_num;
  logic signed [16:0]  s_span;
  logic [DivWidth-1:0] s_den, s_an;
  logic                s_sat, s_neg;
  logic [DvdWidth-1:0] s_dvd;

  assign s_num  = (19'(raw_r) <<< 1) - 19'(smin_r) - 19'(smax_r);
  assign s_span = 17'(smax_r) - 17'(smin_r);
  assign s_den  = (s_span < 17'sd2) ? 17'd2 : s_span;
  assign s_an   = s_num[18] ? 17'(-s_num) : 17'(s_num);
  // quotient surely above one when |num| >= 2*den
  assign s_sat  = {1'b0, s_an} >= {s_den, 1'b0};
  assign s_neg  = s_num[18] ^ is_y;
  assign s_dvd  = DvdWidth'({s_an, 15'd0}) + DvdWidth'(s_den >> 1);

  // trigger prep
  logic signed [16:0]  t_num, t_span;
  logic [DivWidth-1:0] t_den;
  logic                t_zero, t_sat;
  logic [DvdWidth-1:0] t_dvd;

  assign t_num  = 17'(raw_r) - 17'(tmin_r);
  assign t_span = 17'(tmax_r) - 17'(tmin_r);
  assign t_den  = (t_span < 17'sd1) ? 17'd1 : t_span;
  assign t_zero = t_num[16] || (t_num == 17'sd0);
  assign t_sat  = !t_zero && (t_num >= t_den);
  assign t_dvd  = DvdWidth'({t_num, 15'd0}) + DvdWidth'(t_den >> 1);

  // deadzone stage: m capped at one, compare 2m with the deadzone
  logic [DivWidth-1:0] m_cap, h_den, m_rest;
  logic [DivWidth:0]   m2;
  logic [15:0]         dz_sel, dz_cap;
  logic                m_zero;
  logic [DvdWidth-1:0] m_dvd;

  assign m_cap  = (sat_r || (quo > OneQ15)) ? OneQ15 : quo;
  assign m2     = {m_cap, 1'b0};
  assign dz_sel = is_right ? rdz_r : ldz_r;
  assign dz_cap = (dz_sel > DzCap) ? DzCap : dz_sel;
  assign m_zero = m2 <= {2'b00, dz_cap};
  assign h_den  = FullQ16 - 17'(dz_cap);
  assign m_rest = 17'(m2 - {2'b00, dz_cap});
  assign m_dvd  = DvdWidth'({m_rest, 15'd0}) + DvdWidth'(h_den >> 1);

  // final values
  level_t v_stick, v_trig, v_new, v_old, cur_x, cur_y;
  delta_t v_delta;
  logic   emit;

  always_comb begin
    if (zero_r) begin
      v_stick = '0;
    end else if (neg_r) begin
      v_stick = 16'(17'd0 - quo);
    end else begin
      v_stick = (quo > 17'd32767) ? LevelMax : quo[15:0];
    end
  end

  assign v_trig  = zero_r ? 16'sd0 : (sat_r ? LevelMax : quo[15:0]);
  assign v_new   = is_trig ? v_trig : v_stick;
  assign cur_x   = is_right ? rsx_r : lsx_r;
  assign cur_y   = is_right ? rsy_r : lsy_r;
  assign v_old   = is_trig ? (is_right ? rtl_r : ltl_r) : (is_y ? cur_y : cur_x);
  assign v_delta = 17'(v_new) - 17'(v_old);
  assign emit    = is_trig || (v_delta != 17'sd0);

  // hat decode
  hat_t    hv, hold, hnew;
  target_t key_old, key_new, key_press;

  always_comb begin
    if (raw_r < -16'sd1) begin
      hv = -2'sd1;
    end else if (raw_r > 16'sd1) begin
      hv = 2'sd1;
    end else begin
      hv = raw_r[1:0];
    end
  end

  assign hold      = is_haty ? haty_r : hatx_r;
  assign hnew      = hold;
  assign key_old   = is_haty ? (hold[1] ? KEY_N : KEY_S) : (hold[1] ? KEY_W : KEY_E);
  assign key_new   = is_haty ? (hv[1] ? KEY_N : KEY_S) : (hv[1] ? KEY_W : KEY_E);
  assign key_press = is_haty ? (hnew[1] ? KEY_N : KEY_S) : (hnew[1] ? KEY_W : KEY_E);

  assign out_free = !out_valid_r || out_chan.ready;

  // next state, divider requests and output words
  always_comb begin
    state_nxt   = state_r;
    div_req     = '0;
    load_out    = 1'b0;
    apply_go    = 1'b0;
    hat_go      = 1'b0;
    kind_nxt    = KIND_KEY;
    target_nxt  = TGT_LEFT;
    level_a_nxt = '0;
    level_b_nxt = '0;
    delta_a_nxt = '0;
    delta_b_nxt = '0;
    pressed_nxt = 1'b0;
    last_nxt    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (in_chan.axis == AX_HATX || in_chan.axis == AX_HATY) ? ST_HAT
                                                                             : ST_PREP;
        end
      end
      ST_PREP: begin
        if (is_stick) begin
          if (s_sat) begin
            state_nxt = ST_MID;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = s_dvd;
            div_req.divisor  = s_den;
            state_nxt        = ST_DIV;
          end
        end else if (t_zero || t_sat) begin
          state_nxt = ST_APPLY;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = t_dvd;
          div_req.divisor  = t_den;
          state_nxt        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (phase2_r || is_trig) ? ST_APPLY : ST_MID;
        end
      end
      ST_MID: begin
        if (m_zero) begin
          state_nxt = ST_APPLY;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = m_dvd;
          div_req.divisor  = h_den;
          state_nxt        = ST_DIV;
        end
      end
      ST_APPLY: begin
        kind_nxt    = is_trig ? KIND_TRIG : KIND_STICK;
        target_nxt  = is_right ? TGT_RIGHT : TGT_LEFT;
        if (is_trig) begin
          level_a_nxt = v_new;
          delta_a_nxt = v_delta;
        end else begin
          level_a_nxt = is_y ? cur_x : v_new;
          level_b_nxt = is_y ? v_new : cur_y;
          delta_a_nxt = is_y ? 17'sd0 : v_delta;
          delta_b_nxt = is_y ? v_delta : 17'sd0;
        end
        if (!emit) begin
          apply_go  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          apply_go  = 1'b1;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_HAT: begin
        if (hv == hold) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          hat_go   = 1'b1;
          load_out = 1'b1;
          if (hold != 2'sd0) begin
            // release of the old direction first
            target_nxt  = key_old;
            pressed_nxt = 1'b0;
            last_nxt    = hv == 2'sd0;
            state_nxt   = (hv != 2'sd0) ? ST_PRESS : ST_IDLE;
          end else begin
            target_nxt  = key_new;
            pressed_nxt = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_PRESS: begin
        // hat register already holds the new direction
        if (out_free) begin
          load_out    = 1'b1;
          target_nxt  = key_press;
          pressed_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  gac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .quotient (quo),
    .done     (div_done)
  );

  // state register and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      sat_r       <= 1'b0;
      zero_r      <= 1'b0;
      phase2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PREP) begin
        neg_r    <= s_neg;
        sat_r    <= is_stick ? s_sat : t_sat;
        zero_r   <= is_stick ? 1'b0 : t_zero;
        phase2_r <= 1'b0;
      end else if (state_r == ST_MID) begin
        zero_r   <= m_zero;
        phase2_r <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldz_r  <= DzReset;
      rdz_r  <= DzReset;
      smin_r <= StkMinReset;
      smax_r <= StkMaxReset;
      tmin_r <= TrgMinReset;
      tmax_r <= TrgMaxReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_DZ:  ldz_r  <= cfg_wdata;
        REG_RIGHT_DZ: rdz_r  <= cfg_wdata;
        REG_STK_MIN:  smin_r <= cfg_wdata;
        REG_STK_MAX:  smax_r <= cfg_wdata;
        REG_TRG_MIN:  tmin_r <= cfg_wdata;
        REG_TRG_MAX:  tmax_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // stored axis values and hat positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsx_r  <= '0;
      lsy_r  <= '0;
      rsx_r  <= '0;
      rsy_r  <= '0;
      ltl_r  <= '0;
      rtl_r  <= '0;
      hatx_r <= '0;
      haty_r <= '0;
    end else begin
      if (apply_go) begin
        case (axis_r)
          AX_LX:   lsx_r <= v_new;
          AX_LY:   lsy_r <= v_new;
          AX_RX:   rsx_r <= v_new;
          AX_RY:   rsy_r <= v_new;
          AX_LT:   ltl_r <= v_new;
          AX_RT:   rtl_r <= v_new;
          default: begin
          end
        endcase
      end
      if (hat_go) begin
        if (is_haty) begin
          haty_r <= hv;
        end else begin
          hatx_r <= hv;
        end
      end
    end
  end

  // captured event and output word
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      axis_r <= in_chan.axis;
      raw_r  <= in_chan.raw_value;
    end
    if (load_out) begin
      kind_r    <= kind_nxt;
      target_r  <= target_nxt;
      level_a_r <= level_a_nxt;
      level_b_r <= level_b_nxt;
      delta_a_r <= delta_a_nxt;
      delta_b_r <= delta_b_nxt;
      pressed_r <= pressed_nxt;
      last_r    <= last_nxt;
    end
  end

  assign in_chan.ready    = state_r == ST_IDLE;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.kind    = kind_r;
  assign out_chan.target  = target_r;
  assign out_chan.level_a = level_a_r;
  assign out_chan.level_b = level_b_r;
  assign out_chan.delta_a = delta_a_r;
  assign out_chan.delta_b = delta_b_r;
  assign out_chan.pressed = pressed_r;
  assign out_chan.last    = last_r;

endmodule

FILE: tb/sv/tb_gamepad_axis_conditioner_top.sv
`timescale 1ns / 100ps
// self-checking bench: predicts stick, trigger and hat words and compares every output word
module tb_gamepad_axis_conditioner_top;
  import gac_pkg::*;

  // settle time after the last word, covers a stick event that sends nothing
  localparam int SettleCycles = 80;
  // cycles without any handshake before the run is declared hung
  localparam int StallLimit = 4000;
  localparam int PhaseEvents = 200;
  localparam int PhaseCount = 8;

  // one output word as the block presents it
  typedef struct packed {
    kind_t   kind;
    target_t target;
    level_t  level_a;
    level_t  level_b;
    delta_t  delta_a;
    delta_t  delta_b;
    logic    pressed;
    logic    last;
  } result_word_t;

  // axis state mirror plus the queue of words still owed by the block
  class axis_result_tracker;
    logic [15:0]  dz_left, dz_right;
    level_t       stk_lo, stk_hi, trg_lo, trg_hi;
    level_t       lx, ly, rx, ry, lt, rt;
    hat_t         hat_h, hat_v;
    result_word_t expected_words[$];
    int           mismatches;

    function new();
      dz_left = DzReset;
      dz_right = DzReset;
      stk_lo = StkMinReset;
      stk_hi = StkMaxReset;
      trg_lo = TrgMinReset;
      trg_hi = TrgMaxReset;
      lx = '0; ly = '0; rx = '0; ry = '0; lt = '0; rt = '0;
      hat_h = '0;
      hat_v = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        REG_LEFT_DZ:  dz_left = value;
        REG_RIGHT_DZ: dz_right = value;
        REG_STK_MIN:  stk_lo = level_t'(value);
        REG_STK_MAX:  stk_hi = level_t'(value);
        REG_TRG_MIN:  trg_lo = level_t'(value);
        REG_TRG_MAX:  trg_hi = level_t'(value);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(kind_t k, target_t t, level_t a, level_t b, delta_t da,
                            delta_t db, logic p, logic l);
      result_word_t w;
      w = '{kind: k, target: t, level_a: a, level_b: b, delta_a: da, delta_b: db,
            pressed: p, last: l};
      expected_words = {expected_words, w};
    endfunction

    // centre, scale, clamp, deadzone rescale, optional y flip
    function level_t stick_level(level_t raw, logic [15:0] dz, bit invert);
      longint num, span, den, an, m, m16, h, s, dzc;
      num = 2 * longint'(raw) - longint'(stk_lo) - longint'(stk_hi);
      span = longint'(stk_hi) - longint'(stk_lo);
      den = (span < 2) ? 2 : span;
      an = (num < 0) ? -num : num;
      m = (an * 32768 + den / 2) / den;
      if (m > 32768) m = 32768;
      dzc = longint'(dz);
      if (dzc > longint'(DzCap)) dzc = longint'(DzCap);
      m16 = 2 * m;
      if (m16 <= dzc) return '0;
      h = 65536 - dzc;
      s = ((m16 - dzc) * 32768 + h / 2) / h;
      if (s > 32768) s = 32768;
      if ((num < 0) != invert) return level_t'(-s);
      return (s > 32767) ? LevelMax : level_t'(s);
    endfunction

    function level_t trigger_level(level_t raw);
      longint num, span, den, m;
      num = longint'(raw) - longint'(trg_lo);
      span = longint'(trg_hi) - longint'(trg_lo);
      den = (span < 1) ? 1 : span;
      if (num <= 0) return '0;
      m = (num * 32768 + den / 2) / den;
      return (m > 32767) ? LevelMax : level_t'(m);
    endfunction

    // release of the old direction first, then press of the new one
    function void hat_event(level_t raw, bit vertical);
      hat_t    v, old;
      target_t neg_key, pos_key;
      neg_key = vertical ? KEY_N : KEY_W;
      pos_key = vertical ? KEY_S : KEY_E;
      if (raw < -16'sd1) v = -2'sd1;
      else if (raw > 16'sd1) v = 2'sd1;
      else v = hat_t'(raw);
      old = vertical ? hat_v : hat_h;
      if (v == old) return;
      if (vertical) hat_v = v;
      else hat_h = v;
      if (old != 0)
        push_word(KIND_KEY, (old < 0) ? neg_key : pos_key, '0, '0, '0, '0, 1'b0, v == 0);
      if (v != 0)
        push_word(KIND_KEY, (v < 0) ? neg_key : pos_key, '0, '0, '0, '0, 1'b1, 1'b1);
    endfunction

    function void accept_event(axis_t axis, level_t raw);
      bit     right, is_y;
      level_t v, old;
      delta_t d;
      case (axis)
        AX_LX, AX_LY, AX_RX, AX_RY: begin
          right = (axis == AX_RX) || (axis == AX_RY);
          is_y = (axis == AX_LY) || (axis == AX_RY);
          v = stick_level(raw, right ? dz_right : dz_left, is_y);
          old = is_y ? (right ? ry : ly) : (right ? rx : lx);
          d = delta_t'(longint'(v) - longint'(old));
          if (right) begin
            if (is_y) ry = v;
            else rx = v;
          end else begin
            if (is_y) ly = v;
            else lx = v;
          end
          if (d != 0)
            push_word(KIND_STICK, right ? TGT_RIGHT : TGT_LEFT, right ? rx : lx,
                      right ? ry : ly, is_y ? delta_t'(0) : d, is_y ? d : delta_t'(0),
                      1'b0, 1'b1);
        end
        AX_LT, AX_RT: begin
          v = trigger_level(raw);
          old = (axis == AX_RT) ? rt : lt;
          d = delta_t'(longint'(v) - longint'(old));
          if (axis == AX_RT) rt = v;
          else lt = v;
          push_word(KIND_TRIG, (axis == AX_RT) ? TGT_RIGHT : TGT_LEFT, v, '0, d, '0,
                    1'b0, 1'b1);
        end
        AX_HATX: hat_event(raw, 1'b0);
        default: hat_event(raw, 1'b1);
      endcase
    endfunction

    function string fmt(result_word_t w);
      return $sformatf("kind=%0d target=%0d a=%0d b=%0d da=%0d db=%0d pressed=%0b last=%0b",
                       w.kind, w.target, w.level_a, w.level_b, w.delta_a, w.delta_b,
                       w.pressed, w.last);
    endfunction

    function void check_word(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        if (mismatches < 10) $display("unexpected output word: %s", fmt(got));
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind || got.target !== want.target ||
          got.level_a !== want.level_a || got.level_b !== want.level_b ||
          got.delta_a !== want.delta_a || got.delta_b !== want.delta_b ||
          got.pressed !== want.pressed || got.last !== want.last) begin
        if (mismatches < 10) begin
          $display("output word mismatch at %0t", $realtime);
          $display("  expected %s", fmt(want));
          $display("  actual   %s", fmt(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // bench-side drivers, known from time zero
  logic        in_valid = 1'b0;
  axis_t       in_axis = AX_LX;
  level_t      in_raw = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = REG_LEFT_DZ;
  logic [15:0] cfg_wdata = '0;

  // when set, neither side inserts gaps
  bit          quiet = 1'b0;
  int          ready_hold = 0;
  int          stall_count = 0;
  bit          watchdog_tripped = 1'b0;
  level_t      last_raw [8];
  result_word_t seen_word;
  axis_result_tracker tracker;

  gac_in_if  in_chan ();
  gac_out_if out_chan ();

  assign in_chan.valid = in_valid;
  assign in_chan.axis = in_axis;
  assign in_chan.raw_value = in_raw;
  assign out_chan.ready = out_ready;

  gamepad_axis_conditioner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // gap lengths: mostly from the shortest range, now and then from the longest
  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(2, 1);
    if (r < 90) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  function automatic level_t span_pick(level_t a, level_t b);
    int lo, hi;
    lo = (a < b) ? int'(a) : int'(b);
    hi = (a < b) ? int'(b) : int'(a);
    return level_t'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  // raw values biased toward the configured range, with repeats and wild readings
  function automatic level_t random_raw(axis_t ax);
    int     r;
    level_t lo, hi;
    r = $urandom_range(99);
    if (ax == AX_HATX || ax == AX_HATY) begin
      if (r < 80) return level_t'(int'($urandom_range(2)) - 1);
      return level_t'($urandom);
    end
    lo = (ax == AX_LT || ax == AX_RT) ? tracker.trg_lo : tracker.stk_lo;
    hi = (ax == AX_LT || ax == AX_RT) ? tracker.trg_hi : tracker.stk_hi;
    if (r < 10) return last_raw[ax];
    if (r < 65) return span_pick(lo, hi);
    if (r < 80) begin
      case ($urandom_range(3))
        0: return lo;
        1: return hi;
        2: return level_t'((int'(lo) + int'(hi)) / 2);
        default: return '0;
      endcase
    end
    return level_t'($urandom);
  endfunction

  // offer one word; returns at the edge it is taken, valid left high
  task automatic send_event(axis_t ax, level_t raw);
    int gap;
    gap = (!quiet && $urandom_range(99) < 40) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_axis <= ax;
    in_raw <= raw;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // sender holds off until every owed word is out, then lets the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  // only ever called with the block idle
  task automatic write_settings(logic [15:0] dzl, logic [15:0] dzr, logic [15:0] smin,
                                logic [15:0] smax, logic [15:0] tmin, logic [15:0] tmax);
    drain_block();
    write_reg(REG_LEFT_DZ, dzl);
    write_reg(REG_RIGHT_DZ, dzr);
    write_reg(REG_STK_MIN, smin);
    write_reg(REG_STK_MAX, smax);
    write_reg(REG_TRG_MIN, tmin);
    write_reg(REG_TRG_MAX, tmax);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    axis_t  ax;
    level_t raw;
    for (int n = 0; n < count; n++) begin
      // one full pause in the middle of every phase
      if (n == count / 2) drain_block();
      ax = axis_t'($urandom_range(7));
      raw = random_raw(ax);
      last_raw[ax] = raw;
      send_event(ax, raw);
    end
  endtask

  // receiver: random stalls unless in a quiet stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(99) < 30) ready_hold = idle_length();
    end
  end

  // monitor: predict on every accepted event, check every accepted word,
  // and count cycles without progress for the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        tracker.accept_event(in_chan.axis, in_chan.raw_value);
      if (out_chan.valid && out_chan.ready) begin
        seen_word = '{kind: out_chan.kind, target: out_chan.target,
                      level_a: out_chan.level_a, level_b: out_chan.level_b,
                      delta_a: out_chan.delta_a, delta_b: out_chan.delta_b,
                      pressed: out_chan.pressed, last: out_chan.last};
        tracker.check_word(seen_word);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_count = 0;
      else
        stall_count = stall_count + 1;
      if (stall_count >= StallLimit) watchdog_tripped = 1'b1;
    end
  end

  initial begin
    wait (watchdog_tripped);
    $display("simulation failed");
    $finish;
  end

  initial begin
    level_t stk_a, stk_b, trg_a, trg_b, swap;
    tracker = new();
    foreach (last_raw[i]) last_raw[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stick extremes, unchanged stick, deadzone, y flip
    send_event(AX_LX, 16'sd32767);
    send_event(AX_LX, -16'sd32768);
    send_event(AX_LX, 16'sd0);
    send_event(AX_LX, 16'sd0);
    send_event(AX_LY, 16'sd32767);
    send_event(AX_LY, 16'sd1000);
    send_event(AX_RX, -16'sd32768);
    send_event(AX_RY, 16'sd100);
    // triggers: full, zero, below range, saturation, midpoint
    send_event(AX_LT, 16'sd255);
    send_event(AX_LT, 16'sd0);
    send_event(AX_LT, -16'sd100);
    send_event(AX_RT, 16'sd32767);
    send_event(AX_RT, 16'sd128);
    // hat: press from centre, reversal, unchanged, back to centre, clamped readings
    send_event(AX_HATX, 16'sd1);
    send_event(AX_HATX, -16'sd1);
    send_event(AX_HATX, -16'sd1);
    send_event(AX_HATX, 16'sd0);
    send_event(AX_HATY, -16'sd300);
    send_event(AX_HATY, 16'sd32767);
    send_event(AX_HATY, 16'sd0);
    // deadzone above the cap, inverted stick and trigger ranges
    write_settings(16'hFFFF, 16'hFFFF, 16'd1000, -16'sd1000, 16'sd300, 16'sd10);
    send_event(AX_RX, 16'sd32767);
    send_event(AX_RX, -16'sd5);
    send_event(AX_LT, 16'sd305);
    send_event(AX_LT, 16'sd299);

    // random phases across several register settings
    for (int phase = 0; phase < PhaseCount; phase++) begin
      quiet = (phase % 4 == 3);
      case (phase)
        0: write_settings(DzReset, DzReset, StkMinReset, StkMaxReset, TrgMinReset,
                          TrgMaxReset);
        1: write_settings(16'd0, 16'd0, -16'sd32768, 16'sd32767, 16'sd0, 16'sd255);
        2: write_settings(DzCap, 16'hFFFF, 16'sd0, 16'sd1023, -16'sd32768, 16'sd32767);
        4: write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'sd1000, -16'sd1000, 16'sd200, 16'sd10);
        5: write_settings(16'd0, DzCap, 16'sd500, 16'sd500, 16'sd0, 16'sd0);
        default: begin
          stk_a = level_t'($urandom);
          stk_b = level_t'($urandom);
          trg_a = level_t'($urandom);
          trg_b = level_t'($urandom);
          // mostly well-ordered ranges, sometimes inverted
          if ($urandom_range(99) < 75 && stk_a > stk_b) begin
            swap = stk_a; stk_a = stk_b; stk_b = swap;
          end
          if ($urandom_range(99) < 75 && trg_a > trg_b) begin
            swap = trg_a; trg_a = trg_b; trg_b = swap;
          end
          write_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                         stk_a, stk_b, trg_a, trg_b);
        end
      endcase
      run_random(PhaseEvents);
    end

    quiet = 1'b0;
    drain_block();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
